@@ sv/ambs_pkg.sv @@
// Shared types, codes and key text for the AT modem bring-up sequencer.
package ambs_pkg;

	localparam int LINE_DEPTH = 64;
	localparam int LEN_W = $clog2(LINE_DEPTH + 1);
	localparam int ADDR_W = $clog2(LINE_DEPTH);

	localparam int KEY_COUNT = 6;
	localparam int KEY_MAX_LEN = 13;
	localparam int IDX_W = $clog2(KEY_MAX_LEN);

	localparam int KEY_READY = 0;
	localparam int KEY_OK = 1;
	localparam int KEY_RST = 2;
	localparam int KEY_CIFSR = 3;
	localparam int KEY_ERROR = 4;
	localparam int KEY_SYSRDY = 5;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [IDX_W:0] KEY_LEN [KEY_COUNT] = '{
		5'd5, 5'd2, 5'd6, 5'd8, 5'd5, 5'd13
	};

	localparam logic [7:0] KEY_TEXT [KEY_COUNT][KEY_MAX_LEN] = '{
		'{"r", "e", "a", "d", "y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00},
		'{"A", "T", "+", "R", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"A", "T", "+", "C", "I", "F", "S", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"E", "r", "r", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"[", "S", "y", "s", "t", "e", "m", " ", "R", "e", "a", "d", "y"}
	};

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_RESET = 3'd1,
		CMD_ECHO_OFF = 3'd2,
		CMD_JOIN = 3'd3,
		CMD_ADDRESS = 3'd4,
		CMD_MULTI = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		LINK_UNKNOWN = 2'd0,
		LINK_INIT = 2'd1,
		LINK_READY = 2'd2,
		LINK_UP = 2'd3
	} link_t;

	localparam logic [2:0] LED_RED_ONE = 3'b001;
	localparam logic [2:0] LED_GREEN = 3'b010;
	localparam logic [2:0] LED_RED_TWO = 3'b100;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_SCAN,
		SQ_LAST,
		SQ_EMIT
	} seq_state_t;

endpackage

@@ sv/ambs_ram.sv @@
// Generic single-port-write, registered-read RAM.
module ambs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/at_modem_bringup_sequencer.sv @@
// Top level of the AT modem bring-up sequencer: line assembly, key matching and bring-up steps.
//
// Channel  Dir  Beat contents
// s_*      in   tuser: action; tdata: rx_byte
// m_*      out  tdata: command, led_bits, link_state, address_line, stray_ok, unknown_line
//
// An ordinary byte is stored in the line RAM while it has room; a line feed is dropped. A start
// beat goes straight to the emit state. A carriage return ending a line of n bytes compares
// min(n, 13) bytes, one byte read per cycle from the line RAM into the shared key comparator.
// The input is not ready until the result is loaded into the output register; a held result
// delays only the next result. Reset clears all control state; the line RAM is not cleared.
module at_modem_bringup_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [2:0] command, [5:3] led_bits, [7:6] link_state,
	                              // [8] address_line, [9] stray_ok, [10] unknown_line
);
	import ambs_pkg::*;

	seq_state_t state_q, state_d;

	logic [LEN_W-1:0]     len_q;
	logic [IDX_W-1:0]     idx_q, scan_last_q, idx_s1;
	logic                 vld_s1;
	logic [KEY_COUNT-1:0] match_q, match_init;
	logic                 act_q;

	link_t      mod_q, mod_d;
	cmd_t       pend_q, pend_d, cmd_d;
	logic       awa_q, awa_d, exp_q, exp_d, echo_q, echo_d, verb_q, verb_d;
	logic [2:0] led_q, led_d;
	logic       addr_d, stray_d, unk_d;

	logic              accept, emit_go, is_cr, is_lf, ram_we;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic              m_tvalid_q;
	logic [10:0]       out_q;

	assign accept = s_tvalid && s_tready;
	assign is_cr = (s_tdata == CHAR_CR);
	assign is_lf = (s_tdata == CHAR_LF);
	assign emit_go = (state_q == SQ_EMIT) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (accept && s_tuser) begin
					state_d = SQ_EMIT;
				end else if (accept && is_cr && len_q != '0) begin
					state_d = SQ_SCAN;
				end
			end
			SQ_SCAN: begin
				if (idx_q == scan_last_q) begin
					state_d = SQ_LAST;
				end
			end
			SQ_LAST: state_d = SQ_EMIT;
			SQ_EMIT: begin
				if (emit_go) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == SQ_IDLE);
		ram_we = accept && !s_tuser && !is_cr && !is_lf && (len_q < LEN_W'(LINE_DEPTH));
		ram_raddr = ADDR_W'(idx_q);
	end

	always_comb begin
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (k == KEY_SYSRDY) begin
				match_init[k] = (len_q >= LEN_W'(KEY_MAX_LEN));
			end else begin
				match_init[k] = (len_q == LEN_W'(KEY_LEN[k]));
			end
		end
	end

	ambs_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(len_q[ADDR_W-1:0]),
		.wdata(s_tdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		mod_d = mod_q;
		pend_d = pend_q;
		awa_d = awa_q;
		exp_d = exp_q;
		echo_d = echo_q;
		verb_d = verb_q;
		led_d = led_q;
		cmd_d = CMD_NONE;
		addr_d = 1'b0;
		stray_d = 1'b0;
		unk_d = 1'b0;
		if (act_q) begin
			pend_d = CMD_RESET;
			cmd_d = CMD_RESET;
		end else if (awa_q) begin
			led_d = led_q | LED_RED_ONE;
			addr_d = 1'b1;
			awa_d = 1'b0;
		end else if (match_q[KEY_READY]) begin
			if (mod_q == LINK_INIT) begin
				mod_d = LINK_READY;
				pend_d = CMD_ECHO_OFF;
				cmd_d = CMD_ECHO_OFF;
			end
		end else if (match_q[KEY_OK]) begin
			case (pend_q)
				CMD_RESET: mod_d = LINK_INIT;
				CMD_ECHO_OFF: begin
					pend_d = CMD_JOIN;
					cmd_d = CMD_JOIN;
					led_d = led_q | LED_RED_TWO;
					echo_d = 1'b0;
				end
				CMD_JOIN: begin
					mod_d = LINK_UP;
					exp_d = 1'b1;
					pend_d = CMD_ADDRESS;
					verb_d = 1'b1;
					cmd_d = CMD_ADDRESS;
				end
				CMD_ADDRESS: begin
					pend_d = CMD_MULTI;
					cmd_d = CMD_MULTI;
				end
				CMD_MULTI: led_d = led_q | LED_GREEN;
				default: stray_d = 1'b1;
			endcase
		end else if (match_q[KEY_RST]) begin
			led_d = led_q | LED_RED_TWO;
			mod_d = LINK_INIT;
		end else if (match_q[KEY_CIFSR]) begin
			led_d = led_q | LED_GREEN;
			awa_d = 1'b1;
		end else if (match_q[KEY_ERROR]) begin
			led_d = led_q ^ LED_RED_ONE;
		end else if (mod_q == LINK_INIT && match_q[KEY_SYSRDY]) begin
			mod_d = LINK_READY;
			pend_d = CMD_ECHO_OFF;
			cmd_d = CMD_ECHO_OFF;
			led_d = led_q | LED_RED_ONE;
		end else if (exp_q) begin
			if (pend_q == CMD_ADDRESS) begin
				exp_d = 1'b0;
				led_d = led_q | LED_RED_ONE;
				addr_d = 1'b1;
			end
		end else if (mod_q == LINK_INIT || mod_q == LINK_UNKNOWN) begin
			unk_d = 1'b0;
		end else if (echo_q) begin
			unk_d = 1'b0;
		end else if (verb_q) begin
			unk_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			len_q <= '0;
			idx_q <= '0;
			scan_last_q <= '0;
			vld_s1 <= 1'b0;
			match_q <= '0;
			act_q <= 1'b0;
			mod_q <= LINK_UNKNOWN;
			pend_q <= CMD_NONE;
			awa_q <= 1'b0;
			exp_q <= 1'b0;
			echo_q <= 1'b1;
			verb_q <= 1'b0;
			led_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= (state_q == SQ_SCAN);
			if (ram_we) begin
				len_q <= len_q + 1'b1;
			end
			if (state_q == SQ_IDLE && accept) begin
				act_q <= s_tuser;
				if (!s_tuser && is_cr && len_q != '0) begin
					len_q <= '0;
					idx_q <= '0;
					match_q <= match_init;
					scan_last_q <= (len_q >= LEN_W'(KEY_MAX_LEN)) ? IDX_W'(KEY_MAX_LEN - 1)
						: IDX_W'(len_q - 1'b1);
				end
			end
			if (state_q == SQ_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end
			if (vld_s1) begin
				for (int k = 0; k < KEY_COUNT; k++) begin
					if (ram_rdata != KEY_TEXT[k][idx_s1]) begin
						match_q[k] <= 1'b0;
					end
				end
			end
			if (emit_go) begin
				mod_q <= mod_d;
				pend_q <= pend_d;
				awa_q <= awa_d;
				exp_q <= exp_d;
				echo_q <= echo_d;
				verb_q <= verb_d;
				led_q <= led_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (emit_go) begin
			out_q <= {unk_d, stray_d, addr_d, mod_d, led_d, cmd_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {5'b0, out_q};

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_DEPTH))
		else $error("line length above depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_SCAN) |-> (idx_q <= scan_last_q))
		else $error("scan index past last byte");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> m_tvalid_q)
		else $error("result not presented after emit");

	a_line_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_IDLE && state_d == SQ_SCAN) |=> (len_q == '0))
		else $error("line length not cleared at end of line");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == SQ_IDLE))
		else $error("line write outside idle");
`endif

endmodule
